// File: hw/rtl/utf8d_pkg.sv
// utf8d_pkg: shared types and constants of the utf-8 code point decoder
// no dependencies; imported by utf8d_front, utf8d_back and the top module
`default_nettype none

package utf8d_pkg;

  // code point width and fixed code points
  localparam int unsigned CP_W = 21;
  localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;
  localparam logic [CP_W-1:0] END_CP         = 21'h000000;

  // default depth of the job queue between front and back
  localparam int unsigned JOB_DEPTH = 4;

  // what a byte leaves after its replacement flush
  typedef enum logic [1:0] {
    TAIL_NONE = 2'd0,  // byte opened or extended a sequence
    TAIL_CP   = 2'd1,  // a decoded code point
    TAIL_REP  = 2'd2,  // invalid lead or stray continuation
    TAIL_END  = 2'd3   // terminating zero byte
  } tail_kind_e;

  // one job: rep_cnt replacements, then the tail result
  typedef struct packed {
    logic [1:0]      rep_cnt;
    tail_kind_e      tail;
    logic [CP_W-1:0] cp;
  } job_t;

  localparam int unsigned JOB_W = $bits(job_t);

endpackage : utf8d_pkg

`default_nettype wire

// File: hw/rtl/utf8d_fifo.sv
// utf8d_fifo: small register queue of fixed-width words, head shown combinationally
// no dependencies on other files
`default_nettype none

module utf8d_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_en_i,
  input  wire logic [Width-1:0] wr_data_i,
  output      logic             full_o,
  input  wire logic             rd_en_i,
  output      logic [Width-1:0] rd_data_o,
  output      logic             valid_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o    = (cnt_q == FullCnt);
  assign valid_o   = (cnt_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule : utf8d_fifo

`default_nettype wire

// File: hw/rtl/utf8d_front.sv
// utf8d_front: tracks the open sequence and emits a job per text byte with results
// depends on utf8d_pkg
`default_nettype none

module utf8d_front import utf8d_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] text_byte_i,
  output      logic       job_push_o,
  output      job_t       job_o
);

  logic [1:0]      exp_q, exp_d;
  logic [1:0]      seen_q, seen_d;
  logic [CP_W-1:0] pv_q, pv_d;

  logic [1:0]      seen_inc;
  logic [CP_W-1:0] pv_shift;
  logic            is_cont;

  assign is_cont  = (text_byte_i[7:6] == 2'b10);
  assign seen_inc = seen_q + 2'd1;
  assign pv_shift = {pv_q[CP_W-7:0], text_byte_i[5:0]};

  // sequence state and job decode
  always_comb begin
    logic lead_path;
    exp_d     = exp_q;
    seen_d    = seen_q;
    pv_d      = pv_q;
    job_o     = '{rep_cnt: 2'd0, tail: TAIL_NONE, cp: END_CP};
    lead_path = 1'b0;

    if (exp_q != 2'd0) begin
      if (is_cont) begin
        if (seen_inc == exp_q) begin
          job_o.tail = TAIL_CP;
          job_o.cp   = pv_shift;
          exp_d      = 2'd0;
          seen_d     = 2'd0;
          pv_d       = '0;
        end else begin
          seen_d = seen_inc;
          pv_d   = pv_shift;
        end
      end else begin
        // broken sequence: flush lead and buffered continuations
        job_o.rep_cnt = seen_inc;
        exp_d         = 2'd0;
        seen_d        = 2'd0;
        pv_d          = '0;
        lead_path     = 1'b1;
      end
    end else begin
      lead_path = 1'b1;
    end

    if (lead_path) begin
      priority if (text_byte_i == 8'h00) begin
        job_o.tail = TAIL_END;
        job_o.cp   = END_CP;
      end else if (text_byte_i[7] == 1'b0) begin
        job_o.tail = TAIL_CP;
        job_o.cp   = CP_W'(text_byte_i);
      end else if (text_byte_i[7:5] == 3'b110) begin
        exp_d  = 2'd1;
        seen_d = 2'd0;
        pv_d   = CP_W'(text_byte_i[4:0]);
      end else if (text_byte_i[7:4] == 4'b1110) begin
        exp_d  = 2'd2;
        seen_d = 2'd0;
        pv_d   = CP_W'(text_byte_i[3:0]);
      end else if (text_byte_i[7:3] == 5'b11110) begin
        exp_d  = 2'd3;
        seen_d = 2'd0;
        pv_d   = CP_W'(text_byte_i[2:0]);
      end else begin
        job_o.tail = TAIL_REP;
        job_o.cp   = REPLACEMENT_CP;
      end
    end
  end

  // only bytes that cause results reach the queue
  assign job_push_o = accept_i && ((job_o.rep_cnt != 2'd0) || (job_o.tail != TAIL_NONE));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q  <= 2'd0;
      seen_q <= 2'd0;
      pv_q   <= '0;
    end else if (accept_i) begin
      exp_q  <= exp_d;
      seen_q <= seen_d;
      pv_q   <= pv_d;
    end
  end

endmodule : utf8d_front

`default_nettype wire

// File: hw/rtl/utf8d_back.sv
// utf8d_back: expands jobs into registered result words, one per cycle while pop keeps up
// depends on utf8d_pkg
`default_nettype none

module utf8d_back import utf8d_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            job_valid_i,
  input  wire job_t            job_i,
  output      logic            job_pop_o,
  input  wire logic            pop_i,
  output      logic            res_valid_o,
  output      logic [CP_W-1:0] code_point_o,
  output      logic            is_replacement_o,
  output      logic            end_of_text_o,
  output      logic            last_of_run_o
);

  logic [1:0]      idx_q, idx_d;
  logic            vld_q, vld_d;
  logic [CP_W-1:0] cp_q, cp_d;
  logic            rep_q, rep_d, end_q, end_d, last_q, last_d;

  logic [2:0] n_total;
  logic       rep_slot, last_slot, load;

  assign n_total   = {1'b0, job_i.rep_cnt} + {2'b00, (job_i.tail != TAIL_NONE)};
  assign rep_slot  = (idx_q < job_i.rep_cnt);
  assign last_slot = (({1'b0, idx_q} + 3'd1) == n_total);
  assign load      = job_valid_i && (!vld_q || pop_i);
  assign job_pop_o = load && last_slot;

  // result selection for the current slot
  always_comb begin
    cp_d   = cp_q;
    rep_d  = rep_q;
    end_d  = end_q;
    last_d = last_q;
    vld_d  = vld_q && !pop_i;
    idx_d  = idx_q;
    if (load) begin
      vld_d  = 1'b1;
      last_d = last_slot;
      idx_d  = last_slot ? 2'd0 : idx_q + 2'd1;
      if (rep_slot) begin
        cp_d  = REPLACEMENT_CP;
        rep_d = 1'b1;
        end_d = 1'b0;
      end else begin
        unique case (job_i.tail)
          TAIL_CP: begin
            cp_d  = job_i.cp;
            rep_d = 1'b0;
            end_d = 1'b0;
          end
          TAIL_REP: begin
            cp_d  = REPLACEMENT_CP;
            rep_d = 1'b1;
            end_d = 1'b0;
          end
          TAIL_END: begin
            cp_d  = END_CP;
            rep_d = 1'b0;
            end_d = 1'b1;
          end
          TAIL_NONE: begin
            cp_d  = END_CP;
            rep_d = 1'b0;
            end_d = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= 2'd0;
    end else begin
      vld_q <= vld_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_q   <= cp_d;
    rep_q  <= rep_d;
    end_q  <= end_d;
    last_q <= last_d;
  end

  assign res_valid_o      = vld_q;
  assign code_point_o     = cp_q;
  assign is_replacement_o = rep_q;
  assign end_of_text_o    = end_q;
  assign last_of_run_o    = last_q;

endmodule : utf8d_back

`default_nettype wire

// File: hw/rtl/utf8_codepoint_decoder_top.sv
// utf8_codepoint_decoder_top: utf-8 byte stream to code point decoder
// depends on utf8d_pkg, utf8d_front, utf8d_fifo, utf8d_back
//
//   side    handshake       word
//   ------  --------------  ---------------------------------------------------
//   input   push / full     text_byte_i (8b)
//   output  empty / pop     code_point_o (21b), is_replacement_o, end_of_text_o,
//                           last_of_run_o
//
// a byte is taken every cycle while the job queue has room; the back end emits
// one result word per cycle while pop keeps up, so valid text runs at one byte per
// cycle and a broken sequence (up to four words for one byte) holds the back end
// until all its words are out while the queue absorbs further bytes.
// a pushed byte's result passes through the queue, then the output register.
// reset clears the sequence state, the queue and the valid flag of the output register.
`default_nettype none

module utf8_codepoint_decoder_top import utf8d_pkg::*; #(
  parameter int unsigned JobDepth = JOB_DEPTH
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push,
  output      logic            full,
  input  wire logic [7:0]      text_byte_i,
  output      logic            empty,
  input  wire logic            pop,
  output      logic [CP_W-1:0] code_point_o,
  output      logic            is_replacement_o,
  output      logic            end_of_text_o,
  output      logic            last_of_run_o
);

  logic accept, job_push, job_full, job_valid, job_pop, res_valid;
  job_t job_in, job_head;
  logic [JOB_W-1:0] job_head_raw;

  assign accept   = push && !job_full;
  assign full     = job_full;
  assign job_head = job_t'(job_head_raw);
  assign empty    = !res_valid;

  // front: sequence tracking
  utf8d_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .text_byte_i (text_byte_i),
    .job_push_o  (job_push),
    .job_o       (job_in)
  );

  // job queue between front and back
  utf8d_fifo #(
    .Width (JOB_W),
    .Depth (JobDepth)
  ) u_job_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (job_push),
    .wr_data_i (job_in),
    .full_o    (job_full),
    .rd_en_i   (job_pop),
    .rd_data_o (job_head_raw),
    .valid_o   (job_valid)
  );

  // back: result expansion
  utf8d_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .job_valid_i      (job_valid),
    .job_i            (job_head),
    .job_pop_o        (job_pop),
    .pop_i            (pop),
    .res_valid_o      (res_valid),
    .code_point_o     (code_point_o),
    .is_replacement_o (is_replacement_o),
    .end_of_text_o    (end_of_text_o),
    .last_of_run_o    (last_of_run_o)
  );

  // replacement words always carry the replacement code point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && is_replacement_o) |-> (code_point_o == REPLACEMENT_CP))
    else $error("replacement word with wrong code point");

  // end marker is a final, non-replacement, zero word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && end_of_text_o) |->
      (last_of_run_o && !is_replacement_o && (code_point_o == END_CP)))
    else $error("malformed end marker");

  // a job is only pushed when the byte is accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push |-> (push && !job_full))
    else $error("job pushed without accepted byte");

  // the queue never pops a job that is not there
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |-> job_valid)
    else $error("job popped from empty queue");

endmodule : utf8_codepoint_decoder_top

`default_nettype wire
